/* rtl/mvn_pkg.sv */
`default_nettype none
package mvn_pkg;
    localparam int MaxVertices = 1024;
    localparam int IdxW = 10;
    localparam int CntW = 11;
    localparam int PosW = 24;
    localparam int SumW = 56;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_VERTEX = 2'd1,
        KIND_TRIANGLE = 2'd2,
        KIND_READ = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_RANGE = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    // one classified command handed from front to back
    typedef struct packed {
        kind_t kind;
        logic bad;
        logic [PosW-1:0] px;
        logic [PosW-1:0] py;
        logic [PosW-1:0] pz;
        logic [IdxW-1:0] ia;
        logic [IdxW-1:0] ib;
        logic [IdxW-1:0] ic;
        logic [CntW-1:0] total;
    } cmd_t;

    function automatic logic signed [SumW-1:0] sat_add(
        input logic signed [SumW-1:0] a,
        input logic signed [SumW-1:0] b
    );
        logic signed [SumW:0] r;
        begin
            r = {a[SumW-1], a} + {b[SumW-1], b};
            if (r[SumW] != r[SumW-1])
            begin
                sat_add = r[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
            end
            else
            begin
                sat_add = r[SumW-1:0];
            end
        end
    endfunction
endpackage
`default_nettype wire

/* rtl/mesh_vertex_normal_engine_top.sv */
// work per transaction: clear, add vertex and a flagged transaction go straight to the
// result; a triangle does three reads and three read-modify-writes of one
// accumulator port; a normal read does a 32-step square root and three 48-step divisions
// queueing: the back handles one transaction at a time; a two-entry queue holds
// more and busy is high while that queue is full; reset: asynchronous active low, clears
// the vertex count and queue, memories keep junk; done strobes one cycle, no stall
`default_nettype none
module mesh_vertex_normal_engine_top (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic busy,
    input  wire logic [1:0] kind,
    input  wire logic [23:0] pos_x,
    input  wire logic [23:0] pos_y,
    input  wire logic [23:0] pos_z,
    input  wire logic [9:0] index_a,
    input  wire logic [9:0] index_b,
    input  wire logic [9:0] index_c,
    output logic done,
    output logic [1:0] status,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic [10:0] vertices_loaded
);
    mvn_pkg::cmd_t fcmd, bcmd;
    logic take, pop, empty, full;

    // front only takes a transaction while the queue has room
    assign busy = full;
    assign take = start && !busy;

    mvn_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .kind(kind),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .index_a(index_a), .index_b(index_b), .index_c(index_c), .cmd(fcmd)
    );

    mvn_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(take), .din(fcmd),
        .pop(pop), .dout(bcmd), .empty(empty), .full(full)
    );

    mvn_back u_back (
        .clk(clk), .rst_n(rst_n), .empty(empty), .cmd(bcmd), .pop(pop),
        .done(done), .status(status), .normal_x(normal_x), .normal_y(normal_y),
        .normal_z(normal_z), .vertices_loaded(vertices_loaded)
    );
endmodule
`default_nettype wire

/* rtl/mvn_front.sv */
`default_nettype none
// accepts commands, range-checks them and tracks the vertex count
module mvn_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic take,
    input  wire logic [1:0] kind,
    input  wire logic [23:0] pos_x,
    input  wire logic [23:0] pos_y,
    input  wire logic [23:0] pos_z,
    input  wire logic [9:0] index_a,
    input  wire logic [9:0] index_b,
    input  wire logic [9:0] index_c,
    output mvn_pkg::cmd_t cmd
);
    logic [mvn_pkg::CntW-1:0] total_reg, total_next;
    logic bad;
    mvn_pkg::kind_t k;

    always_comb
    begin
        k = mvn_pkg::kind_t'(kind);
        bad = 1'b0;
        total_next = total_reg;
        unique case (k)
            mvn_pkg::KIND_CLEAR: total_next = '0;
            mvn_pkg::KIND_VERTEX:
            begin
                if (total_reg >= mvn_pkg::CntW'(mvn_pkg::MaxVertices))
                begin
                    bad = 1'b1;
                end
                else
                begin
                    total_next = total_reg + 1'b1;
                end
            end
            mvn_pkg::KIND_TRIANGLE:
                bad = ({1'b0, index_a} >= total_reg) || ({1'b0, index_b} >= total_reg)
                    || ({1'b0, index_c} >= total_reg);
            default: bad = {1'b0, index_a} >= total_reg;
        endcase
        cmd.kind = k;
        cmd.bad = bad;
        cmd.px = pos_x;
        cmd.py = pos_y;
        cmd.pz = pos_z;
        cmd.ia = (k == mvn_pkg::KIND_VERTEX) ? total_reg[mvn_pkg::IdxW-1:0] : index_a;
        cmd.ib = index_b;
        cmd.ic = index_c;
        cmd.total = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (take)
        begin
            total_reg <= total_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/mvn_queue.sv */
`default_nettype none
// short command fifo between front and back
module mvn_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  mvn_pkg::cmd_t din,
    input  wire logic pop,
    output mvn_pkg::cmd_t dout,
    output logic empty,
    output logic full
);
    mvn_pkg::cmd_t mem_reg [mvn_pkg::QueueDepth];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign dout = mem_reg[rp_reg];
    assign empty = (cnt_reg == 2'd0);
    assign full = (cnt_reg == 2'(mvn_pkg::QueueDepth));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

/* rtl/mvn_back.sv */
`default_nettype none
// executes commands against the position and accumulator memories
module mvn_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic empty,
    input  mvn_pkg::cmd_t cmd,
    output logic pop,
    output logic done,
    output logic [1:0] status,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic [10:0] vertices_loaded
);
    localparam int SW = mvn_pkg::SumW;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_RDA   = 16'h0002,
        S_RDB   = 16'h0004,
        S_RDC   = 16'h0008,
        S_MUL   = 16'h0010,
        S_CRS   = 16'h0020,
        S_WRA   = 16'h0040,
        S_WRB   = 16'h0080,
        S_WRC   = 16'h0100,
        S_NRD   = 16'h0200,
        S_MAG   = 16'h0400,
        S_SHF   = 16'h0800,
        S_SQ    = 16'h1000,
        S_SQRT  = 16'h2000,
        S_DIV   = 16'h4000,
        S_OUT   = 16'h8000
    } state_t;

    state_t st_reg;
    mvn_pkg::cmd_t c_reg;

    // memories
    logic [3*mvn_pkg::PosW-1:0] pos_mem [mvn_pkg::MaxVertices];
    logic [3*SW-1:0] sum_mem [mvn_pkg::MaxVertices];
    logic [3*mvn_pkg::PosW-1:0] pos_q;
    logic [3*SW-1:0] sum_q;
    logic [mvn_pkg::IdxW-1:0] raddr;
    logic pwe, swe;
    logic [mvn_pkg::IdxW-1:0] waddr;
    logic [3*SW-1:0] wdata;

    // last accumulator write, forwarded when a corner repeats back to back
    logic [3*SW-1:0] wlast_reg;
    logic [mvn_pkg::IdxW-1:0] wlast_addr_reg;
    logic wlast_v_reg;
    logic [3*SW-1:0] base;

    logic signed [24:0] pa_x, pa_y, pa_z, pb_x, pb_y, pb_z;
    logic signed [24:0] e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [49:0] p_reg [6];
    logic signed [SW-1:0] nx_reg, ny_reg, nz_reg;
    logic [1:0] wsel_reg;
    logic [1:0] mi_reg;
    logic [2:0] phase_reg;

    // normalize datapath
    logic [SW-1:0] mg_reg [3];
    logic sg_reg [3];
    logic [61:0] q_reg;
    logic [61:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0] it_reg;
    logic [5:0] dcnt_reg;
    logic [47:0] drem_reg;
    logic [15:0] dq_reg;
    logic [1:0] comp_reg;
    logic [15:0] res_reg [3];

    logic [5:0] blen;
    logic [SW-1:0] mmax;

    always_ff @(posedge clk)
    begin
        if (pwe) pos_mem[waddr] <= {c_reg.px, c_reg.py, c_reg.pz};
        if (swe) sum_mem[waddr] <= wdata;
        pos_q <= pos_mem[raddr];
        sum_q <= sum_mem[raddr];
    end

    always_comb
    begin
        raddr = c_reg.ia;
        if (st_reg == S_RDB) raddr = c_reg.ib;
        if (st_reg == S_RDC || (st_reg == S_MUL && phase_reg == 3'd0)) raddr = c_reg.ic;
        if (st_reg == S_WRA) raddr = c_reg.ib;
        if (st_reg == S_WRB) raddr = c_reg.ic;
        mmax = mg_reg[0];
        if (mg_reg[1] > mmax) mmax = mg_reg[1];
        if (mg_reg[2] > mmax) mmax = mg_reg[2];
        blen = '0;
        for (int i = 0; i < SW; i++)
        begin
            if (mmax[i]) blen = 6'(i + 1);
        end
    end

    assign pop = (st_reg == S_IDLE) && !empty;

    function automatic logic signed [24:0] sx(input logic [23:0] v);
        sx = {v[23], v};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (!empty) st_reg <= cmd.bad || cmd.kind == mvn_pkg::KIND_CLEAR
                    ? S_OUT : cmd.kind == mvn_pkg::KIND_VERTEX ? S_OUT
                    : cmd.kind == mvn_pkg::KIND_TRIANGLE ? S_RDA : S_NRD;
                S_RDA: st_reg <= S_RDB;
                S_RDB: st_reg <= S_RDC;
                S_RDC: st_reg <= S_MUL;
                S_MUL: if (phase_reg == 3'd3) st_reg <= S_CRS;
                S_CRS: st_reg <= S_WRA;
                S_WRA: st_reg <= S_WRB;
                S_WRB: st_reg <= S_WRC;
                S_WRC: st_reg <= S_OUT;
                S_NRD: if (phase_reg == 3'd1) st_reg <= S_MAG;
                S_MAG: st_reg <= S_SHF;
                S_SHF: st_reg <= S_SQ;
                S_SQ: if (mi_reg == 2'd2) st_reg <= S_SQRT;
                S_SQRT: if (it_reg == 5'd0) st_reg <= S_DIV;
                S_DIV: if (dcnt_reg == 6'd0 && comp_reg == 2'd2) st_reg <= S_OUT;
                S_OUT:
                begin
                    st_reg <= S_IDLE;
                    done <= 1'b1;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_comb
    begin
        pwe = (st_reg == S_OUT) && c_reg.kind == mvn_pkg::KIND_VERTEX && !c_reg.bad;
        swe = pwe || st_reg == S_WRA || st_reg == S_WRB || st_reg == S_WRC;
        waddr = st_reg == S_WRB ? c_reg.ib : st_reg == S_WRC ? c_reg.ic : c_reg.ia;
        // the read issued alongside a write to the same entry returns the old value
        base = (wlast_v_reg && wlast_addr_reg == waddr) ? wlast_reg : sum_q;
        wdata = '0;
        if (!pwe)
        begin
            wdata = {mvn_pkg::sat_add(base[3*SW-1:2*SW], nx_reg),
                     mvn_pkg::sat_add(base[2*SW-1:SW], ny_reg),
                     mvn_pkg::sat_add(base[SW-1:0], nz_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        wlast_v_reg <= swe;
        wlast_addr_reg <= waddr;
        wlast_reg <= wdata;
        if (st_reg == S_IDLE)
        begin
            c_reg <= cmd;
            phase_reg <= '0;
            mi_reg <= '0;
            comp_reg <= '0;
            for (int i = 0; i < 3; i++) res_reg[i] <= '0;
        end
        if (st_reg == S_RDB)
        begin
            pa_x <= sx(pos_q[71:48]); pa_y <= sx(pos_q[47:24]); pa_z <= sx(pos_q[23:0]);
        end
        if (st_reg == S_RDC)
        begin
            pb_x <= sx(pos_q[71:48]); pb_y <= sx(pos_q[47:24]); pb_z <= sx(pos_q[23:0]);
        end
        if (st_reg == S_MUL)
        begin
            phase_reg <= phase_reg + 3'd1;
            if (phase_reg == 3'd1)
            begin
                // pa holds a, pb holds b, pos_q holds c
                e1x <= pb_x - pa_x; e1y <= pb_y - pa_y; e1z <= pb_z - pa_z;
                e2x <= sx(pos_q[71:48]) - pb_x; e2y <= sx(pos_q[47:24]) - pb_y;
                e2z <= sx(pos_q[23:0]) - pb_z;
            end
            if (phase_reg == 3'd2)
            begin
                p_reg[0] <= e1y * e2z; p_reg[1] <= e1z * e2y;
                p_reg[2] <= e1z * e2x; p_reg[3] <= e1x * e2z;
                p_reg[4] <= e1x * e2y; p_reg[5] <= e1y * e2x;
            end
        end
        if (st_reg == S_CRS)
        begin
            nx_reg <= SW'(p_reg[0]) - SW'(p_reg[1]);
            ny_reg <= SW'(p_reg[2]) - SW'(p_reg[3]);
            nz_reg <= SW'(p_reg[4]) - SW'(p_reg[5]);
        end
        if (st_reg == S_NRD) phase_reg <= phase_reg + 3'd1;
        if (st_reg == S_MAG)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sg_reg[i] <= sum_q[(3-i)*SW-1];
                mg_reg[i] <= sum_q[(3-i)*SW-1] ? SW'(-sum_q[(3-i)*SW-1 -: SW])
                    : sum_q[(3-i)*SW-1 -: SW];
            end
        end
        if (st_reg == S_SHF)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mg_reg[i] <= (blen > 6'd30) ? (mg_reg[i] >> (blen - 6'd30)) : mg_reg[i];
            end
            q_reg <= '0;
        end
        if (st_reg == S_SQ)
        begin
            q_reg <= q_reg + 62'(mg_reg[mi_reg][29:0] * mg_reg[mi_reg][29:0]);
            mi_reg <= mi_reg + 2'd1;
            rem_reg <= '0;
            root_reg <= '0;
            it_reg <= 5'd31;
        end
        if (st_reg == S_SQRT)
        begin
            // one result bit per cycle, restoring
            logic [63:0] trial;
            logic [63:0] r2;
            r2 = {rem_reg, 2'b00} | 64'(q_reg >> {it_reg, 1'b0} & 62'd3);
            trial = {30'd0, root_reg, 2'b01};
            if (r2 >= trial)
            begin
                rem_reg <= 62'(r2 - trial);
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= 62'(r2);
                root_reg <= {root_reg[30:0], 1'b0};
            end
            if (it_reg != 5'd0) it_reg <= it_reg - 5'd1;
            dcnt_reg <= 6'd47;
            drem_reg <= '0;
            dq_reg <= '0;
        end
        if (st_reg == S_DIV)
        begin
            // long division of (mg*65536+len) by 2*len, one bit per cycle
            logic [47:0] num;
            logic [48:0] r2;
            logic [32:0] den;
            num = {mg_reg[comp_reg][29:0], 16'd0} + 48'(root_reg);
            den = {root_reg, 1'b0};
            r2 = {drem_reg, num[dcnt_reg]};
            if (r2 >= 49'(den))
            begin
                drem_reg <= 48'(r2 - 49'(den));
                dq_reg <= {dq_reg[14:0], 1'b1} | {dq_reg[15], 15'd0};
            end
            else
            begin
                drem_reg <= 48'(r2);
                dq_reg <= {dq_reg[14:0], 1'b0} | {dq_reg[15], 15'd0};
            end
            if (dcnt_reg != 6'd0)
            begin
                dcnt_reg <= dcnt_reg - 6'd1;
            end
            else
            begin
                logic [15:0] fq;
                logic ge;
                ge = r2 >= 49'(den);
                fq = {dq_reg[14:0], ge};
                if (dq_reg[15] || fq[15]) fq = 16'h7fff;
                res_reg[comp_reg] <= sg_reg[comp_reg] ? 16'(-fq) : fq;
                comp_reg <= comp_reg + 2'd1;
                dcnt_reg <= 6'd47;
                drem_reg <= '0;
                dq_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_OUT)
        begin
            vertices_loaded <= c_reg.total;
            status <= mvn_pkg::ST_OK;
            normal_x <= '0;
            normal_y <= '0;
            normal_z <= '0;
            if (c_reg.bad) status <= mvn_pkg::ST_RANGE;
            else if (c_reg.kind == mvn_pkg::KIND_READ)
            begin
                if (root_reg == '0 || mmax == '0) status <= mvn_pkg::ST_ZERO;
                else
                begin
                    normal_x <= res_reg[0];
                    normal_y <= res_reg[1];
                    normal_z <= res_reg[2];
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/mvn_checker.sv */
`default_nettype none
module mvn_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic [1:0] status,
    input wire logic [15:0] normal_x
);
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != 2'd3) else $error("bad status");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != mvn_pkg::ST_OK |-> normal_x == 16'd0) else $error("normal on error");
    a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({start, busy})) else $error("handshake unknown");
endmodule

bind mesh_vertex_normal_engine_top mvn_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .normal_x(normal_x)
);
`default_nettype wire
